// ===== sv/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcgr_pkg: shared types and constants of the text console renderer
// Beat payloads, function, command and character codes, register indexes,
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  localparam int ROW_W     = 5;   // cell row counter, font height is 5 bits
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = 12;  // quotient bits of screen_width / font_width

  // input functions
  localparam logic [1:0] FUNC_PUT   = 2'd0;
  localparam logic [1:0] FUNC_LOAD  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // result commands
  localparam logic [1:0] CMD_ROW_WRITE = 2'd0;
  localparam logic [1:0] CMD_SCROLL    = 2'd1;
  localparam logic [1:0] CMD_CLEAR     = 2'd2;

  // control characters
  localparam logic [7:0] CHAR_NL = 8'h0a;
  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_BS = 8'h08;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_W     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_H     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_CNT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H   = 3'd6;

  // register reset values
  localparam logic [31:0] RST_FG_COLOR  = 32'hffff_ffff;
  localparam logic [31:0] RST_BG_COLOR  = 32'hff00_0000;
  localparam logic [4:0]  RST_FONT_W    = 5'd8;
  localparam logic [4:0]  RST_FONT_H    = 5'd16;
  localparam logic [8:0]  RST_GLYPH_CNT = 9'd256;
  localparam logic [11:0] RST_SCREEN_W  = 12'd1024;
  localparam logic [11:0] RST_SCREEN_H  = 12'd768;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [7:0]  glyph_index;
    logic [3:0]  glyph_row;
    logic [15:0] row_bits;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [15:0] pixel_mask;
    logic [31:0] fill_foreground;
    logic [31:0] fill_background;
    logic        last;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_ERASE,
    KIND_GLYPH,
    KIND_CURSOR,
    KIND_SCROLL,
    KIND_CLEAR
  } res_kind_t;

  typedef struct packed {
    logic      capture;    // latch glyph base, start column divider
    logic      load_wr;    // write glyph row from input beat
    logic      org;        // register cell origin, restart row counter
    logic      cur_clear;
    logic      col_zero;
    logic      col_inc;
    logic      col_dec;
    logic      bs_wrap;    // back to last column of previous line
    logic      line_inc;
    logic      line_dec;
    logic      emit;
    logic      row_adv;
    res_kind_t kind;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic row_last;
    logic col_is_zero;
    logic line_is_zero;
    logic wrap;
    logic scroll;
    logic div_done;
  } dp_status_t;

endpackage

// ===== sv/tcgr_div.sv =====
// ----------------------------------------------------------------------------
// tcgr_div: serial column count divider
// Restoring divide of the screen width by the cell width, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module tcgr_div
  import tcgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [11:0] dividend,
  input  logic [4:0]  divisor,
  output logic [11:0] quotient,
  output logic        done
);

  logic [3:0]  cnt_r, cnt_nxt;
  logic [11:0] q_r, q_nxt;
  logic [4:0]  rem_r, rem_nxt;
  logic [4:0]  dvs_r;
  logic [5:0]  trial;
  logic        ge;

  assign trial = {rem_r, q_r[11]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    if (start) begin
      cnt_nxt = 4'(DIV_STEPS);
      q_nxt   = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 4'd1;
      q_nxt   = {q_r[10:0], ge};
      rem_nxt = ge ? 5'(trial - {1'b0, dvs_r}) : trial[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign quotient = q_r;
  assign done     = (cnt_r == '0);

endmodule

// ===== sv/tcgr_dp.sv =====
// ----------------------------------------------------------------------------
// tcgr_dp: console datapath
// Configuration registers, cursor, cell origin, glyph row store, column
// divider and the result register.
// ----------------------------------------------------------------------------
module tcgr_dp
  import tcgr_pkg::*;
#(
  parameter int MAX_GLYPHS      = 256,
  parameter int MAX_FONT_HEIGHT = 16,
  parameter int MAX_FONT_WIDTH  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  localparam int DEPTH = MAX_GLYPHS * MAX_FONT_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration
  logic [31:0] fg_r, bg_r;
  logic [4:0]  fw_r, fh_r;
  logic [8:0]  gcnt_r;
  logic [11:0] sw_r, sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r   <= RST_FG_COLOR;
      bg_r   <= RST_BG_COLOR;
      fw_r   <= RST_FONT_W;
      fh_r   <= RST_FONT_H;
      gcnt_r <= RST_GLYPH_CNT;
      sw_r   <= RST_SCREEN_W;
      sh_r   <= RST_SCREEN_H;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FG_COLOR:  fg_r   <= cfg_data;
        REG_BG_COLOR:  bg_r   <= cfg_data;
        REG_FONT_W:    fw_r   <= cfg_data[4:0];
        REG_FONT_H:    fh_r   <= cfg_data[4:0];
        REG_GLYPH_CNT: gcnt_r <= cfg_data[8:0];
        REG_SCREEN_W:  sw_r   <= cfg_data[11:0];
        REG_SCREEN_H:  sh_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [4:0]  w_eff, h_eff;
  logic [11:0] sw_eff, sh_eff;
  logic [15:0] wmask;

  always_comb begin
    if (fw_r == '0) begin
      w_eff = 5'd1;
    end else if ({1'b0, fw_r} > 6'(MAX_FONT_WIDTH)) begin
      w_eff = 5'(MAX_FONT_WIDTH);
    end else begin
      w_eff = fw_r;
    end
    if (fh_r == '0) begin
      h_eff = 5'd1;
    end else if ({1'b0, fh_r} > 6'(MAX_FONT_HEIGHT)) begin
      h_eff = 5'(MAX_FONT_HEIGHT);
    end else begin
      h_eff = fh_r;
    end
    sw_eff = (sw_r == '0) ? 12'd1 : sw_r;
    sh_eff = (sh_r == '0) ? 12'd1 : sh_r;
    wmask  = ~(16'hffff >> w_eff);
  end

  // column divider, run on every put
  logic [11:0] div_q;
  logic        div_done;

  tcgr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.capture),
    .dividend (sw_eff),
    .divisor  (w_eff),
    .quotient (div_q),
    .done     (div_done)
  );

  // cursor
  logic [11:0] col_r, col_nxt, line_r, line_nxt;

  always_comb begin
    priority if (cmd.cur_clear || cmd.col_zero) begin
      col_nxt = '0;
    end else if (cmd.col_inc) begin
      col_nxt = col_r + 12'd1;
    end else if (cmd.col_dec) begin
      col_nxt = col_r - 12'd1;
    end else if (cmd.bs_wrap) begin
      col_nxt = (div_q == '0) ? 12'd0 : div_q - 12'd1;
    end else begin
      col_nxt = col_r;
    end
    priority if (cmd.cur_clear) begin
      line_nxt = '0;
    end else if (cmd.line_inc) begin
      line_nxt = line_r + 12'd1;
    end else if (cmd.line_dec || cmd.bs_wrap) begin
      line_nxt = line_r - 12'd1;
    end else begin
      line_nxt = line_r;
    end
  end

  // cell origin and row counter
  logic [16:0]      ox_r, oy_r;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             row_last;

  assign row_last = (row_r == ROW_W'(h_eff - 5'd1));

  always_comb begin
    if (cmd.org) begin
      row_nxt = '0;
    end else if (cmd.row_adv) begin
      row_nxt = row_last ? '0 : row_r + 1'b1;
    end else begin
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      line_r <= '0;
      row_r  <= '0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
      row_r  <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.org) begin
      ox_r <= {5'b0, col_r} * {12'b0, w_eff};
      oy_r <= {5'b0, line_r} * {12'b0, h_eff};
    end
  end

  // glyph row store; read runs one row ahead of the emitted row
  logic [15:0]   store [DEPTH];
  logic [15:0]   rdata_r;
  logic [AW-1:0] base_r, rd_addr, wr_addr;
  logic          idx_ok, ld_ok;

  assign idx_ok = ({1'b0, in_data.char_code} < gcnt_r) &&
                  ({1'b0, in_data.char_code} < 9'(MAX_GLYPHS));
  assign ld_ok  = ({1'b0, in_data.glyph_index} < 9'(MAX_GLYPHS)) &&
                  ({2'b0, in_data.glyph_row} < 6'(MAX_FONT_HEIGHT));
  assign wr_addr = AW'(int'(in_data.glyph_index) * MAX_FONT_HEIGHT +
                       int'(in_data.glyph_row));
  assign rd_addr = AW'(32'(base_r) + 32'(row_nxt));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      base_r <= idx_ok ? AW'(int'(in_data.char_code) * MAX_FONT_HEIGHT) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && ld_ok) begin
      store[wr_addr] <= in_data.row_bits;
    end
    rdata_r <= store[rd_addr];
  end

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, res;

  always_comb begin
    res.command         = CMD_ROW_WRITE;
    res.pixel_x         = ox_r[11:0];
    res.pixel_y         = oy_r[11:0] + 12'(row_r);
    res.pixel_mask      = '0;
    res.fill_foreground = fg_r;
    res.fill_background = bg_r;
    res.last            = cmd.last;
    unique case (cmd.kind)
      KIND_ERASE:  res.pixel_mask = '0;
      KIND_GLYPH:  res.pixel_mask = rdata_r & wmask;
      KIND_CURSOR: res.pixel_mask = wmask;
      KIND_SCROLL: begin
        res.command = CMD_SCROLL;
        res.pixel_x = '0;
        res.pixel_y = 12'(h_eff);
      end
      KIND_CLEAR: begin
        res.command = CMD_CLEAR;
        res.pixel_x = '0;
        res.pixel_y = '0;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.out_free     = !out_valid_r || out_ready;
  assign status.row_last     = row_last;
  assign status.col_is_zero  = (col_r == '0);
  assign status.line_is_zero = (line_r == '0);
  assign status.wrap         = ox_r >= {5'b0, sw_eff};
  assign status.scroll       = oy_r >= {5'b0, sh_eff};
  assign status.div_done     = div_done;

endmodule

// ===== sv/tcgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tcgr_ctrl: console sequencer
// Steps one input item through its cell passes, scroll and clear results.
// ----------------------------------------------------------------------------
module tcgr_ctrl
  import tcgr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERASE,
    ST_NL_ORG,
    ST_NL_CHK,
    ST_SCROLL,
    ST_CUR_ORG,
    ST_CURSOR,
    ST_BS_DIV,
    ST_BS_ORG,
    ST_BS_ERASE,
    ST_GLYPH,
    ST_ADV_ORG,
    ST_ADV_CHK,
    ST_CLEAR
  } state_t;

  typedef enum logic [1:0] {
    CLS_PRINT,
    CLS_NL,
    CLS_CR,
    CLS_BS
  } char_cls_t;

  state_t    state_r, state_nxt;
  char_cls_t cls_r, cls_nxt, cls_in;

  always_comb begin
    priority if (in_data.char_code == CHAR_NL) begin
      cls_in = CLS_NL;
    end else if (in_data.char_code == CHAR_CR) begin
      cls_in = CLS_CR;
    end else if (in_data.char_code == CHAR_BS) begin
      cls_in = CLS_BS;
    end else begin
      cls_in = CLS_PRINT;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cls_nxt   = cls_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.func)
            FUNC_PUT: begin
              cmd.capture = 1'b1;
              cmd.org     = 1'b1;
              cls_nxt     = cls_in;
              state_nxt   = ST_ERASE;
            end
            FUNC_LOAD:  cmd.load_wr = 1'b1;
            FUNC_CLEAR: state_nxt = ST_CLEAR;
            default: ;
          endcase
        end
      end
      ST_ERASE: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.row_adv = 1'b1;
          cmd.kind    = KIND_ERASE;
          // return, and backspace at the origin, end on the erase pass
          cmd.last    = status.row_last && ((cls_r == CLS_CR) ||
                        ((cls_r == CLS_BS) && status.col_is_zero &&
                         status.line_is_zero));
          if (status.row_last) begin
            unique case (cls_r)
              CLS_NL: begin
                cmd.line_inc = 1'b1;
                cmd.col_zero = 1'b1;
                state_nxt    = ST_NL_ORG;
              end
              CLS_CR: begin
                cmd.col_zero = 1'b1;
                state_nxt    = ST_IDLE;
              end
              CLS_BS: begin
                priority if (!status.col_is_zero) begin
                  cmd.col_dec = 1'b1;
                  state_nxt   = ST_BS_ORG;
                end else if (!status.line_is_zero) begin
                  state_nxt = ST_BS_DIV;
                end else begin
                  state_nxt = ST_IDLE;
                end
              end
              CLS_PRINT: state_nxt = ST_GLYPH;
              default: ;
            endcase
          end
        end
      end
      ST_NL_ORG: begin
        cmd.org   = 1'b1;
        state_nxt = ST_NL_CHK;
      end
      ST_NL_CHK: begin
        state_nxt = status.scroll ? ST_SCROLL : ST_CURSOR;
      end
      ST_SCROLL: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = KIND_SCROLL;
          cmd.line_dec = 1'b1;
          state_nxt    = ST_CUR_ORG;
        end
      end
      ST_CUR_ORG: begin
        cmd.org   = 1'b1;
        state_nxt = ST_CURSOR;
      end
      ST_CURSOR: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.row_adv = 1'b1;
          cmd.kind    = KIND_CURSOR;
          cmd.last    = status.row_last;
          if (status.row_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BS_DIV: begin
        if (status.div_done) begin
          cmd.bs_wrap = 1'b1;
          state_nxt   = ST_BS_ORG;
        end
      end
      ST_BS_ORG: begin
        cmd.org   = 1'b1;
        state_nxt = ST_BS_ERASE;
      end
      ST_BS_ERASE: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.row_adv = 1'b1;
          cmd.kind    = KIND_ERASE;
          if (status.row_last) begin
            state_nxt = ST_CURSOR;
          end
        end
      end
      ST_GLYPH: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.row_adv = 1'b1;
          cmd.kind    = KIND_GLYPH;
          if (status.row_last) begin
            cmd.col_inc = 1'b1;
            state_nxt   = ST_ADV_ORG;
          end
        end
      end
      ST_ADV_ORG: begin
        cmd.org   = 1'b1;
        state_nxt = ST_ADV_CHK;
      end
      ST_ADV_CHK: begin
        if (status.wrap) begin
          cmd.line_inc = 1'b1;
          cmd.col_zero = 1'b1;
          state_nxt    = ST_NL_ORG;
        end else begin
          state_nxt = ST_CURSOR;
        end
      end
      ST_CLEAR: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.kind      = KIND_CLEAR;
          cmd.last      = 1'b1;
          cmd.cur_clear = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cls_r   <= CLS_PRINT;
    end else begin
      state_r <= state_nxt;
      cls_r   <= cls_nxt;
    end
  end

endmodule

// ===== sv/text_console_glyph_renderer.sv =====
// ----------------------------------------------------------------------------
// text_console_glyph_renderer: framebuffer text console
// Input beats put a character, load one glyph row or clear the screen.
// A put turns into framebuffer row writes (mask bit set = foreground,
// clear = background), at most one scroll-up command, and last marks the
// final result beat of each input beat. Loads give no result; a clear gives
// one clear command and homes the cursor.
// Channels: in_* and out_* are valid/ready; cfg_* writes a register by
// index and is always ready. Write configuration only while the block idles.
// The first result beat of a put is the first row of its erase pass.
// The sequencer gives one result beat per cycle during a cell pass while
// out_ready is high, and recomputes the cell origin in an origin state
// before a pass at a new cell. A backspace that wraps a line also waits for
// the column divider, started when the put is accepted.
// Loads and clears are accepted with prior result beats pending; loads back to back.
// The next input beat is accepted as soon as the last result beat is in the
// output register, before it is taken.
// Reset: synchronous active-low; colors and geometry return to defaults,
// cursor homes, the glyph store is not cleared.
// Stall: a low out_ready holds the output register and freezes the pass.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer
  import tcgr_pkg::*;
#(
  parameter int MAX_GLYPHS      = 256,
  parameter int MAX_FONT_HEIGHT = 16,
  parameter int MAX_FONT_WIDTH  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input beats
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // result beats
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // registers are plain flops, a write is always taken
  assign cfg_ready = 1'b1;

  // sequencer: one input beat at a time through its cell passes
  tcgr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: registers, cursor, glyph store, result register
  tcgr_dp #(
    .MAX_GLYPHS      (MAX_GLYPHS),
    .MAX_FONT_HEIGHT (MAX_FONT_HEIGHT),
    .MAX_FONT_WIDTH  (MAX_FONT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
